// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the histogram accumulator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define HBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// The condition must never be true outside reset.
`define HBA_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== src/hba_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Histogram accumulator package
// Beat types, status codes, operation codes and register indexes.
// ---------------------------------------------------------------------------
package hba_pkg;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_IN_RANGE = 2'd0;
  localparam logic [1:0] ST_BELOW    = 2'd1;
  localparam logic [1:0] ST_ABOVE    = 2'd2;

  localparam logic CFG_BIN_ORIGIN = 1'b0;
  localparam logic CFG_BIN_SHIFT  = 1'b1;

  localparam int unsigned SHIFT_RESET = 16;

  typedef struct packed {
    logic               op;
    logic signed [31:0] sample;
    logic        [9:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        [31:0] total_count;
    logic        [10:0] lowest_bin;
    logic signed [10:0] highest_bin;
    logic signed [31:0] min_sample;
    logic signed [31:0] max_sample;
  } stats_t;

  typedef struct packed {
    logic        [9:0]  bin_index;
    logic        [31:0] bin_count;
    logic        [1:0]  status;
    logic        [31:0] total_count;
    logic        [10:0] lowest_bin;
    logic signed [10:0] highest_bin;
    logic signed [31:0] min_sample;
    logic signed [31:0] max_sample;
  } out_item_t;

endpackage

// ===== src/hba_bin_map.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bin mapper
// Maps a sample or a read request to a bin index and a range status.
// ---------------------------------------------------------------------------
module hba_bin_map #(
  parameter int NBINS = 1024
) (
  input  hba_pkg::in_item_t          item_i,
  input  logic signed [31:0]         origin_i,
  input  logic        [4:0]          shift_i,
  output logic [$clog2(NBINS)-1:0]   idx_o,
  output logic [1:0]                 status_o
);

  localparam int BIN_W = $clog2(NBINS);
  localparam logic [BIN_W-1:0] LAST_IDX = BIN_W'(NBINS - 1);
  localparam logic signed [33:0] NBINS_S = 34'(NBINS);
  localparam logic [31:0] NBINS_U = 32'(NBINS);

  logic signed [33:0] diff;
  logic signed [33:0] bin_raw;
  logic               rd_over;

  assign diff = {{2{item_i.sample[31]}}, item_i.sample}
              - {{2{origin_i[31]}}, origin_i} - 34'sd1;
  assign bin_raw = diff >>> shift_i;
  assign rd_over = {22'd0, item_i.read_index} >= NBINS_U;

  always_comb begin
    idx_o    = '0;
    status_o = hba_pkg::ST_IN_RANGE;
    if (item_i.op == hba_pkg::OP_ADD) begin
      if (bin_raw[33]) begin
        idx_o    = '0;
        status_o = hba_pkg::ST_BELOW;
      end else if (bin_raw >= NBINS_S) begin
        idx_o    = LAST_IDX;
        status_o = hba_pkg::ST_ABOVE;
      end else begin
        idx_o = bin_raw[BIN_W-1:0];
      end
    end else begin
      if (rd_over) begin
        idx_o    = LAST_IDX;
        status_o = hba_pkg::ST_ABOVE;
      end else begin
        idx_o = BIN_W'(item_i.read_index);
      end
    end
  end

endmodule

// ===== src/hba_count_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bin count memory
// Synchronous count store with one read port, one write port and a
// clearing sweep after reset.
// ---------------------------------------------------------------------------
module hba_count_ram #(
  parameter int NBINS      = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(NBINS)-1:0] rd_addr_i,
  output logic [COUNT_BITS-1:0]    rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(NBINS)-1:0] wr_addr_i,
  input  logic [COUNT_BITS-1:0]    wr_data_i,
  output logic                     busy_o
);

  localparam int BIN_W = $clog2(NBINS);
  localparam logic [BIN_W-1:0] LAST_IDX = BIN_W'(NBINS - 1);

  logic [COUNT_BITS-1:0] mem [NBINS];
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  clr_q;
  logic [BIN_W-1:0]      clr_addr_q;
  logic                  mem_we;
  logic [BIN_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == LAST_IDX) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign mem_we    = clr_q || wr_en_i;
  assign mem_waddr = clr_q ? clr_addr_q : wr_addr_i;
  assign mem_wdata = clr_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_q;

endmodule

// ===== src/hba_stats.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Histogram statistics
// Sample total, occupied bin range and sample extremes.
// ---------------------------------------------------------------------------
module hba_stats #(
  parameter int NBINS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     upd_i,
  input  logic [$clog2(NBINS)-1:0] idx_i,
  input  logic signed [31:0]       sample_i,
  output hba_pkg::stats_t          stats_o
);

  `include "assert_macros.svh"

  localparam int BIN_W = $clog2(NBINS);
  localparam logic [BIN_W:0] LOW_EMPTY = (BIN_W + 1)'(NBINS);

  logic        [31:0]  total_q, total_d;
  logic        [BIN_W:0] low_q, low_d;
  logic signed [BIN_W:0] high_q, high_d;
  logic signed [31:0]  min_q, min_d;
  logic signed [31:0]  max_q, max_d;
  logic        [BIN_W:0] idx_ext;

  assign idx_ext = {1'b0, idx_i};

  always_comb begin
    total_d = total_q;
    low_d   = low_q;
    high_d  = high_q;
    min_d   = min_q;
    max_d   = max_q;
    if (upd_i) begin
      if (total_q != '1) begin
        total_d = total_q + 32'd1;
      end
      if (idx_ext < low_q) begin
        low_d = idx_ext;
      end
      if ($signed(idx_ext) > high_q) begin
        high_d = $signed(idx_ext);
      end
      if (sample_i < min_q) begin
        min_d = sample_i;
      end
      if (sample_i > max_q) begin
        max_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      low_q   <= LOW_EMPTY;
      high_q  <= '1;
      min_q   <= 32'sh7fffffff;
      max_q   <= 32'sh80000000;
    end else begin
      total_q <= total_d;
      low_q   <= low_d;
      high_q  <= high_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  assign stats_o.total_count = total_d;
  assign stats_o.lowest_bin  = 11'(low_d);
  assign stats_o.highest_bin = 11'(high_d);
  assign stats_o.min_sample  = min_d;
  assign stats_o.max_sample  = max_d;

  `HBA_ASSERT(a_empty_state, clk_i, rst_ni,
    (total_q == '0) |-> (low_q == LOW_EMPTY && high_q == '1))
  `HBA_ASSERT(a_bin_order, clk_i, rst_ni,
    (total_q != '0) |-> ($signed(low_q) <= high_q))
  `HBA_ASSERT(a_sample_order, clk_i, rst_ni,
    (total_q != '0) |-> (min_q <= max_q))

endmodule

// ===== src/histogram_bin_accumulator_unit.sv =====
`timescale 1ns / 1ps
// A beat is registered in s1, then s2, then the output register. Throughput:
// one beat per cycle while the output side is ready and no clear runs; the
// count memory is read in s1 and written back from s2, with forwarding.
// Reset: after rst_ni is released the count memory is cleared one bin per
// cycle over all NBINS bins; no input beat is taken until that sweep ends.
// ---------------------------------------------------------------------------
// Histogram bin accumulator
// Counts signed Q16.16 samples into power-of-two wide bins and reads bins.
// ---------------------------------------------------------------------------
module histogram_bin_accumulator_unit #(
  parameter int NBINS      = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hba_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hba_pkg::out_item_t  out_data_o
);

  `include "assert_macros.svh"

  localparam int BIN_W = $clog2(NBINS);

  logic signed [31:0] origin_q;
  logic [4:0]         shift_q;

  logic               advance;
  logic               ram_busy;
  logic [BIN_W-1:0]   map_idx;
  logic [1:0]         map_status;

  logic               s1_valid_q;
  logic               s1_op_q;
  logic [BIN_W-1:0]   s1_idx_q;
  logic [1:0]         s1_status_q;
  logic signed [31:0] s1_sample_q;

  logic               s2_valid_q;
  logic               s2_op_q;
  logic [BIN_W-1:0]   s2_idx_q;
  logic [1:0]         s2_status_q;
  logic signed [31:0] s2_sample_q;

  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] new_count;
  logic                  wr_en;

  logic                  fwd_valid_q;
  logic [BIN_W-1:0]      fwd_idx_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic               out_valid_q;
  hba_pkg::out_item_t out_data_q;
  hba_pkg::stats_t    stats;
  logic               stats_upd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      shift_q  <= 5'(hba_pkg::SHIFT_RESET);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hba_pkg::CFG_BIN_ORIGIN: origin_q <= cfg_data_i;
        hba_pkg::CFG_BIN_SHIFT:  shift_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance && !ram_busy;

  hba_bin_map #(
    .NBINS (NBINS)
  ) u_map (
    .item_i   (in_data_i),
    .origin_i (origin_q),
    .shift_i  (shift_q),
    .idx_o    (map_idx),
    .status_o (map_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i && in_ready_o;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_op_q     <= in_data_i.op;
      s1_idx_q    <= map_idx;
      s1_status_q <= map_status;
      s1_sample_q <= in_data_i.sample;
      s2_op_q     <= s1_op_q;
      s2_idx_q    <= s1_idx_q;
      s2_status_q <= s1_status_q;
      s2_sample_q <= s1_sample_q;
    end
  end

  assign cur_count = (fwd_valid_q && fwd_idx_q == s2_idx_q) ? fwd_data_q : rd_data;

  always_comb begin
    new_count = cur_count;
    if (s2_op_q == hba_pkg::OP_ADD && cur_count != '1) begin
      new_count = cur_count + 1'b1;
    end
  end

  assign wr_en     = advance && s2_valid_q && s2_op_q == hba_pkg::OP_ADD;
  assign stats_upd = wr_en;

  hba_count_ram #(
    .NBINS      (NBINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (advance),
    .rd_addr_i (s1_idx_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s2_idx_q),
    .wr_data_i (new_count),
    .busy_o    (ram_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (advance) begin
      fwd_valid_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fwd_idx_q  <= s2_idx_q;
      fwd_data_q <= new_count;
    end
  end

  hba_stats #(
    .NBINS (NBINS)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (stats_upd),
    .idx_i    (s2_idx_q),
    .sample_i (s2_sample_q),
    .stats_o  (stats)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_valid_q) begin
      out_data_q.bin_index   <= 10'(s2_idx_q);
      out_data_q.bin_count   <= 32'(new_count);
      out_data_q.status      <= s2_status_q;
      out_data_q.total_count <= stats.total_count;
      out_data_q.lowest_bin  <= stats.lowest_bin;
      out_data_q.highest_bin <= stats.highest_bin;
      out_data_q.min_sample  <= stats.min_sample;
      out_data_q.max_sample  <= stats.max_sample;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `HBA_ASSERT_NEVER(a_no_accept_in_clear, clk_i, rst_ni, ram_busy && in_ready_o)
  `HBA_ASSERT(a_add_nonzero, clk_i, rst_ni,
    (s2_valid_q && s2_op_q == hba_pkg::OP_ADD) |-> (new_count != '0))
  `HBA_ASSERT(a_fwd_tracks_write, clk_i, rst_ni,
    wr_en |=> (fwd_valid_q && fwd_idx_q == $past(s2_idx_q)))

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Histogram bin accumulator testbench
// Streams add and read beats into the accumulator under several bin origin
// and width settings, with random stalls on both sides in most phases. A software mirror of
// the bin counts and running statistics predicts every result beat, and each
// result is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module testbench;

  localparam int NBINS = 1024;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int BEATS_PER_PHASE = 150;
  localparam int PHASES = 7;

  class bin_count_mirror;
    logic [31:0] counts [NBINS];
    logic [31:0] total;
    int low_seen;
    int high_seen;
    int least;
    int greatest;
    int origin;
    int unsigned shift;
    hba_pkg::out_item_t awaited_tallies[$];
    int unsigned failures;

    function new();
      foreach (counts[i]) counts[i] = '0;
      total = '0;
      low_seen = NBINS;
      high_seen = -1;
      least = 32'sh7FFF_FFFF;
      greatest = 32'sh8000_0000;
      origin = 0;
      shift = hba_pkg::SHIFT_RESET;
      failures = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      case (idx)
        hba_pkg::CFG_BIN_ORIGIN: origin = $signed(value);
        hba_pkg::CFG_BIN_SHIFT:  shift = {27'd0, value[4:0]};
        default: ;
      endcase
    endfunction

    task flag(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      failures++;
    endtask

    function void count_beat(hba_pkg::in_item_t beat);
      longint d;
      longint b;
      int x;
      logic [9:0] idx;
      hba_pkg::out_item_t r;
      r.status = hba_pkg::ST_IN_RANGE;
      if (beat.op == hba_pkg::OP_ADD) begin
        x = $signed(beat.sample);
        d = longint'(x) - longint'(origin) - 1;
        b = d >>> shift;
        if (b < 0) begin
          b = 0;
          r.status = hba_pkg::ST_BELOW;
        end else if (b >= NBINS) begin
          b = NBINS - 1;
          r.status = hba_pkg::ST_ABOVE;
        end
        idx = b[9:0];
        if (counts[idx] != 32'hFFFF_FFFF) counts[idx]++;
        if (total != 32'hFFFF_FFFF) total++;
        if (b > high_seen) high_seen = int'(b);
        if (b < low_seen) low_seen = int'(b);
        if (x > greatest) greatest = x;
        if (x < least) least = x;
      end else begin
        idx = beat.read_index;
      end
      r.bin_index   = idx;
      r.bin_count   = counts[idx];
      r.total_count = total;
      r.lowest_bin  = low_seen[10:0];
      r.highest_bin = high_seen[10:0];
      r.min_sample  = least;
      r.max_sample  = greatest;
      awaited_tallies.push_back(r);
    endfunction

    task check_tally(hba_pkg::out_item_t got);
      hba_pkg::out_item_t want;
      if (awaited_tallies.size() == 0) begin
        flag($sformatf("result beat for bin %0d with nothing pending", got.bin_index));
        return;
      end
      want = awaited_tallies.pop_front();
      if (got.bin_index !== want.bin_index)
        flag($sformatf("bin_index got %0d want %0d", got.bin_index, want.bin_index));
      if (got.bin_count !== want.bin_count)
        flag($sformatf("bin_count got %0d want %0d", got.bin_count, want.bin_count));
      if (got.status !== want.status)
        flag($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.total_count !== want.total_count)
        flag($sformatf("total_count got %0d want %0d", got.total_count, want.total_count));
      if (got.lowest_bin !== want.lowest_bin)
        flag($sformatf("lowest_bin got %0d want %0d", got.lowest_bin, want.lowest_bin));
      if (got.highest_bin !== want.highest_bin)
        flag($sformatf("highest_bin got %0d want %0d", got.highest_bin, want.highest_bin));
      if (got.min_sample !== want.min_sample)
        flag($sformatf("min_sample got %h want %h", got.min_sample, want.min_sample));
      if (got.max_sample !== want.max_sample)
        flag($sformatf("max_sample got %h want %h", got.max_sample, want.max_sample));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = hba_pkg::CFG_BIN_ORIGIN;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  hba_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  hba_pkg::out_item_t out_data_o;

  bin_count_mirror mirror;
  int          send_idle_pct = 23;
  int          recv_idle_pct = 71;
  int unsigned cycle_count = 0;
  int          cur_origin = 0;
  int unsigned cur_shift = hba_pkg::SHIFT_RESET;
  int          last_bin = 0;

  histogram_bin_accumulator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) mirror.check_tally(out_data_o);
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic hba_pkg::in_item_t add_beat(logic [31:0] x);
    hba_pkg::in_item_t beat;
    beat.op = hba_pkg::OP_ADD;
    beat.sample = x;
    beat.read_index = '0;
    return beat;
  endfunction

  function automatic hba_pkg::in_item_t read_beat(logic [9:0] idx);
    hba_pkg::in_item_t beat;
    beat.op = hba_pkg::OP_READ;
    beat.sample = '0;
    beat.read_index = idx;
    return beat;
  endfunction

  // Most add beats aim at a chosen bin, often the previous one, so that
  // back-to-back updates of one bin and both bin edges are exercised.
  function automatic hba_pkg::in_item_t random_item();
    hba_pkg::in_item_t beat;
    int unsigned pick;
    longint w;
    longint spot;
    longint x;
    pick = $urandom_range(99);
    w = longint'(1) << cur_shift;
    beat.op = hba_pkg::OP_ADD;
    beat.sample = $urandom;
    beat.read_index = ($urandom_range(1) == 1) ? 10'(last_bin)
                                               : 10'($urandom_range(NBINS - 1));
    if (pick < 15) begin
      beat.op = hba_pkg::OP_READ;
    end else if (pick >= 25) begin
      if (pick < 35)
        spot = ($urandom_range(1) == 1) ? -longint'($urandom_range(3, 1))
                                        : longint'(NBINS + $urandom_range(2));
      else if (pick < 60)
        spot = longint'(last_bin);
      else
        spot = longint'($urandom_range(NBINS - 1));
      case ($urandom_range(3))
        0:       x = 0;
        1:       x = w - 1;
        default: x = longint'($urandom) & (w - 1);
      endcase
      x = longint'(cur_origin) + 1 + spot * w + x;
      beat.sample = x[31:0];
      if (spot >= 0 && spot < NBINS) last_bin = int'(spot);
    end
    return beat;
  endfunction

  task automatic send_item(input hba_pkg::in_item_t beat);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.count_beat(beat);
  endtask

  task automatic write_settings(input logic [31:0] origin, input int unsigned shift);
    logic [31:0] shift_word;
    shift_word = ($urandom & 32'hFFFF_FFE0) | {27'd0, shift[4:0]};
    cfg_valid_i <= 1'b1;
    cfg_index_i <= hba_pkg::CFG_BIN_ORIGIN;
    cfg_data_i  <= origin;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.set_register(hba_pkg::CFG_BIN_ORIGIN, origin);
    cfg_index_i <= hba_pkg::CFG_BIN_SHIFT;
    cfg_data_i  <= shift_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.set_register(hba_pkg::CFG_BIN_SHIFT, shift_word);
    cfg_valid_i <= 1'b0;
    cur_origin = $signed(origin);
    cur_shift = {27'd0, shift[4:0]};
  endtask

  task automatic settle();
    while (mirror.awaited_tallies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    mirror = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(read_beat(10'd0));
    send_item(read_beat(10'd1023));
    send_item(add_beat(32'h0000_0000));
    send_item(add_beat(32'h0000_0001));
    send_item(add_beat(32'h7FFF_FFFF));
    send_item(add_beat(32'h8000_0000));
    send_item(add_beat(32'h0400_0000));
    send_item(add_beat(32'h0400_0001));
    send_item(add_beat(32'h0005_0000));
    send_item(add_beat(32'h0005_0001));
    send_item(add_beat(32'h0005_0001));
    send_item(add_beat(32'h0005_0001));
    send_item(read_beat(10'd5));
    send_item(read_beat(10'd4));
    send_item(read_beat(10'd1023));
    send_item(add_beat(32'hAAAA_AAAA));
    send_item(add_beat(32'h5555_5555));
    send_item(add_beat(32'hFFFF_FFFF));
    send_item(read_beat(10'h2AA));
    send_item(read_beat(10'h155));
    send_item(read_beat(10'd0));

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 23;
      end else if (p == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p > 0) begin
        settle();
        case (p)
          1:       write_settings(32'h8000_0000, 31);
          2:       write_settings(32'h7FFF_FFFF, 0);
          3:       write_settings($urandom, 0);
          4:       write_settings($urandom, $urandom_range(14, 6));
          5:       write_settings(32'hFE00_0000, 16);
          default: write_settings($urandom, $urandom_range(31));
        endcase
      end
      repeat (BEATS_PER_PHASE) send_item(random_item());
      in_valid_i <= 1'b0;
    end
    settle();

    if (mirror.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/hba_pkg.sv
src/hba_bin_map.sv
src/hba_count_ram.sv
src/hba_stats.sv
src/histogram_bin_accumulator_unit.sv
bench/testbench.sv
